@@ sv/lbf_pkg.sv @@
// Shared constants and types for the line versus box face hit test.
package lbf_pkg;

  localparam int CW      = 32;            // Q16.16 coordinate width
  localparam int DW      = CW + 1;        // exact difference width
  localparam int FRAC    = 16;            // fraction bits
  localparam int NUMW    = DW + FRAC;     // scaled numerator width
  localparam int PW      = CW + DW;       // quotient times direction
  localparam int DIV_LAT = DW + 2;        // divider latency in cycles

  typedef struct packed {
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic [2:0][CW-1:0] org;
    logic [2:0][DW-1:0] dir;
  } geo_t;

endpackage

@@ sv/lbf_div.sv @@
// Pipelined restoring divider: saturated Q16.16 quotient (n << 16) / d.
module lbf_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lbf_pkg::DW-1:0]    n,
  input  logic signed [lbf_pkg::DW-1:0]    d,
  output logic signed [lbf_pkg::CW-1:0]    q
);

  localparam int DW   = lbf_pkg::DW;
  localparam int CW   = lbf_pkg::CW;
  localparam int NUMW = lbf_pkg::NUMW;
  localparam int HIW  = NUMW - DW;

  logic [DW-1:0] rem  [0:DW];
  logic [DW-1:0] low  [0:DW];
  logic [DW-1:0] quo  [0:DW];
  logic [DW-1:0] dm   [0:DW];
  logic          neg  [0:DW];
  logic          ovf  [0:DW];

  logic [DW-1:0]   n_mag;
  logic [DW-1:0]   d_mag;
  logic [NUMW-1:0] num;

  always_comb begin
    n_mag = n[DW-1] ? DW'(-n) : DW'(n);
    d_mag = d[DW-1] ? DW'(-d) : DW'(d);
    num   = {n_mag, {lbf_pkg::FRAC{1'b0}}};
  end

  // entry: magnitudes and early overflow check (quotient >= 2^DW)
  always_ff @(posedge clk) begin
    if (en) begin
      dm[0]  <= d_mag;
      neg[0] <= n[DW-1] ^ d[DW-1];
      ovf[0] <= {{(DW-HIW){1'b0}}, num[NUMW-1:DW]} >= d_mag;
      rem[0] <= {{(DW-HIW){1'b0}}, num[NUMW-1:DW]};
      low[0] <= num[DW-1:0];
      quo[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DW:0] trial;
    logic        take;
    always_comb begin
      trial = {rem[k], low[k][DW-1]};
      take  = trial >= {1'b0, dm[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? DW'(trial - {1'b0, dm[k]}) : trial[DW-1:0];
        low[k+1] <= {low[k][DW-2:0], 1'b0};
        quo[k+1] <= {quo[k][DW-2:0], take};
        dm[k+1]  <= dm[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[DW]) begin
        if (ovf[DW] || quo[DW] > DW'(33'h0_8000_0000))
          q <= {1'b1, {(CW-1){1'b0}}};
        else
          q <= CW'(-quo[DW][CW-1:0]);
      end else begin
        if (ovf[DW] || quo[DW][DW-1] || quo[DW][CW-1])
          q <= {1'b0, {(CW-1){1'b1}}};
        else
          q <= quo[DW][CW-1:0];
      end
    end
  end

endmodule

@@ sv/line_box_face_hit_test.sv @@
// Top level: streaming line versus axis-aligned box face hit test.
//
// Usage:
//   Input channel in_valid/in_stall carries one test item: box corners
//   (box_min_*, box_max_*) and two points on a line (origin_*, through_*),
//   all signed Q16.16. Output channel out_valid/out_stall returns one item
//   per test, hit = 1 when the line crosses any of the six box faces with
//   the other two coordinates inside the box bounds (inclusive).
// Throughput: one item per cycle while out_stall does not hold the pipeline.
//   Set by the pipelined 33-stage restoring dividers (one quotient bit per stage, six in parallel, one per face).
// Stages: input reg, differences, divider (35), multiply, face compare, OR.
// Stall: the whole pipeline holds while the output item waits and
//   out_stall is high; in_stall follows, nothing is lost or repeated.
// Reset: rst clears all valid bits and holds in_stall high; payload
//   registers are not reset.
module line_box_face_hit_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [lbf_pkg::CW-1:0]   box_min_x,
  input  logic signed [lbf_pkg::CW-1:0]   box_min_y,
  input  logic signed [lbf_pkg::CW-1:0]   box_min_z,
  input  logic signed [lbf_pkg::CW-1:0]   box_max_x,
  input  logic signed [lbf_pkg::CW-1:0]   box_max_y,
  input  logic signed [lbf_pkg::CW-1:0]   box_max_z,
  input  logic signed [lbf_pkg::CW-1:0]   origin_x,
  input  logic signed [lbf_pkg::CW-1:0]   origin_y,
  input  logic signed [lbf_pkg::CW-1:0]   origin_z,
  input  logic signed [lbf_pkg::CW-1:0]   through_x,
  input  logic signed [lbf_pkg::CW-1:0]   through_y,
  input  logic signed [lbf_pkg::CW-1:0]   through_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit
);

  localparam int CW    = lbf_pkg::CW;
  localparam int DW    = lbf_pkg::DW;
  localparam int PW    = lbf_pkg::PW;
  localparam int SW    = PW - lbf_pkg::FRAC;   // scaled product width
  localparam int VW    = SW + 1;               // coordinate at crossing
  localparam int DLAT  = lbf_pkg::DIV_LAT;
  localparam int LAT   = DLAT + 5;

  // global advance: everything moves unless the output item is held
  logic adv;
  logic vld [0:LAT-1];

  assign adv       = !(vld[LAT-1] && out_stall);
  assign in_stall  = rst || !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // stage 0: input capture
  logic [2:0][CW-1:0] r_lo, r_hi, r_org, r_thr;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_lo  <= {box_min_z, box_min_y, box_min_x};
      r_hi  <= {box_max_z, box_max_y, box_max_x};
      r_org <= {origin_z, origin_y, origin_x};
      r_thr <= {through_z, through_y, through_x};
    end
  end

  // stage 1: direction and plane distances; geometry delay line
  lbf_pkg::geo_t     geo_d [0:DLAT];
  logic [5:0][DW-1:0] n_face;

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_d[0].lo  <= r_lo;
      geo_d[0].hi  <= r_hi;
      geo_d[0].org <= r_org;
      for (int a = 0; a < 3; a++) begin
        geo_d[0].dir[a] <= DW'($signed({r_thr[a][CW-1], r_thr[a]})
                              - $signed({r_org[a][CW-1], r_org[a]}));
        n_face[2*a]     <= DW'($signed({r_lo[a][CW-1], r_lo[a]})
                              - $signed({r_org[a][CW-1], r_org[a]}));
        n_face[2*a+1]   <= DW'($signed({r_hi[a][CW-1], r_hi[a]})
                              - $signed({r_org[a][CW-1], r_org[a]}));
      end
      for (int k = 1; k <= DLAT; k++) geo_d[k] <= geo_d[k-1];
    end
  end

  // geometry aligned with the products, for the compare stage
  lbf_pkg::geo_t     geo_m;
  logic [5:0]        face_ok;

  always_ff @(posedge clk) begin
    if (adv) geo_m <= geo_d[DLAT];
  end

  // per face: divider, two products, two bound checks
  for (genvar f = 0; f < 6; f++) begin : g_face
    localparam int A = f / 2;
    localparam int B = (A + 1) % 3;
    localparam int C = (A + 2) % 3;

    logic signed [CW-1:0] q;
    logic signed [PW-1:0] prod_b, prod_c;
    logic signed [VW-1:0] v_b, v_c;
    logic                 in_b, in_c;

    lbf_div u_div (
      .clk (clk),
      .en  (adv),
      .n   ($signed(n_face[f])),
      .d   ($signed(geo_d[0].dir[A])),
      .q   (q)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        prod_b <= q * $signed(geo_d[DLAT].dir[B]);
        prod_c <= q * $signed(geo_d[DLAT].dir[C]);
      end
    end

    // floor shift by the fraction, then offset by the start point
    always_comb begin
      v_b  = VW'($signed(geo_m.org[B])) + VW'($signed(prod_b[PW-1:lbf_pkg::FRAC]));
      v_c  = VW'($signed(geo_m.org[C])) + VW'($signed(prod_c[PW-1:lbf_pkg::FRAC]));
      in_b = (VW'($signed(geo_m.lo[B])) <= v_b) && (v_b <= VW'($signed(geo_m.hi[B])));
      in_c = (VW'($signed(geo_m.lo[C])) <= v_c) && (v_c <= VW'($signed(geo_m.hi[C])));
    end

    // zero direction on the face axis skips both faces of that axis
    always_ff @(posedge clk) begin
      if (adv) face_ok[f] <= in_b && in_c && (geo_m.dir[A] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) hit <= |face_ok;
  end

endmodule
